// ===== hw/rtl/wesm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Escape sequence matcher package
// Word types, action and status codes, the fixed pattern strings and the
// per-shell ordered group lists shared by the matcher modules.
// ----------------------------------------------------------------------------
package wesm_pkg;

    // Sizes of the pattern set and group lists.
    localparam int NUM_PATTERNS    = 32;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int GROUP_SLOTS     = 16;
    localparam int NUM_GROUPS      = 5;
    localparam int NUM_SHELLS      = 2;
    localparam int POS_W           = $clog2(MAX_PATTERN_LEN);
    localparam int LEN_W           = POS_W + 1;
    localparam int PAT_BITS        = 8 * MAX_PATTERN_LEN;

    // Action codes.
    localparam logic [1:0] ACT_CHECK  = 2'd0;
    localparam logic [1:0] ACT_ENABLE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    // Status codes, also used as the per-pattern advance result.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Wildcard symbols inside a pattern.
    localparam logic [7:0] SYM_PRINTS    = 8'h12;
    localparam logic [7:0] SYM_NOT_LF_CR = 8'h13;
    localparam logic [7:0] SYM_NOT_LF    = 8'h14;
    localparam logic [7:0] SYM_DIGITS    = 8'h16;
    localparam logic [7:0] SYM_ANY       = 8'h18;
    localparam logic [7:0] CHR_LF        = 8'h0A;
    localparam logic [7:0] CHR_CR        = 8'h0D;

    // Input and result words.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
        logic [2:0] group;
    } in_word_t;

    typedef struct packed {
        logic [1:0] match_status;
        logic [4:0] matched_pattern;
    } out_word_t;

    // Decision of the group arbiter for one word.
    typedef struct packed {
        logic [NUM_PATTERNS-1:0] check_mask;
        logic [NUM_PATTERNS-1:0] touch_mask;
        out_word_t               result;
    } wesm_sel_t;

    // Pattern strings, first character in the most significant used byte.
    localparam logic [PAT_BITS-1:0] PAT_STR [NUM_PATTERNS] = '{
        0:  "\033[0;30m\033[0m\033[1;37m\033[0m",
        1:  "\033[0;34m\033[0m\033[0;31m\033[0m",
        2:  "\033[0;34m\033[0m\033[0;31m\033[0m\033[\026D",
        3:  "\033P\022\033\\",
        4:  "\007",
        5:  "\030",
        6:  "\033[0m\033[27m\033[24m\015\033[\026C",
        7:  " \015\023",
        8:  "\015\024",
        9:  "\015\n",
        10: "\010",
        11: "\033[\026C",
        12: "\033[\026D",
        13: "\033[\026A",
        14: "\033[\026K",
        15: "\033[\026P",
        16: "\033[\026@",
        17: "\007",
        default: '0
    };

    localparam logic [LEN_W-1:0] PAT_LEN [NUM_PATTERNS] = '{
        0: 6'd22, 1: 6'd22, 2: 6'd26, 3: 6'd5, 4: 6'd1, 5: 6'd1,
        6: 6'd19, 7: 6'd3, 8: 6'd2, 9: 6'd2, 10: 6'd1, 11: 6'd4,
        12: 6'd4, 13: 6'd4, 14: 6'd4, 15: 6'd4, 16: 6'd4, 17: 6'd1,
        default: 6'd0
    };

    // Ordered member lists per shell and group; zero marks an empty slot.
    localparam logic [4:0] GROUP_ROM [NUM_SHELLS][NUM_GROUPS][GROUP_SLOTS] = '{
        '{
            '{5'd5, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
            '{5'd1, 5'd4, 5'd8, 5'd12, 5'd11, 5'd15, 5'd16, 5'd17,
              5'd13, 5'd18, 5'd14, 5'd9, 5'd10, 5'd0, 5'd0, 5'd0},
            '{5'd1, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
            '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
            '{5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}
        },
        '{
            '{5'd5, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
            '{5'd1, 5'd2, 5'd8, 5'd12, 5'd11, 5'd15, 5'd16, 5'd17,
              5'd13, 5'd18, 5'd14, 5'd9, 5'd10, 5'd4, 5'd0, 5'd0},
            '{5'd1, 5'd3, 5'd4, 5'd7, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
            '{5'd3, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
            '{5'd6, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
              5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0}
        }
    };

    // Character at a position of a pattern; zero at or past the end.
    function automatic logic [7:0] sym_at(input logic [PAT_BITS-1:0] str,
                                          input logic [LEN_W-1:0]    len,
                                          input logic [LEN_W-1:0]    idx);
        logic [LEN_W-1:0]    sel;
        logic [PAT_BITS-1:0] shifted;
        sel     = len - idx - LEN_W'(1);
        shifted = str >> {sel, 3'b000};
        if (idx < len)
            return shifted[7:0];
        else
            return 8'h00;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wesm_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pattern lane
// Advances one pattern by one byte: compares the byte against the symbol at
// the current position, handles wildcards and returns the next position and
// enable bit together with the advance result.
// ----------------------------------------------------------------------------
module wesm_lane (
    input  wire logic [wesm_pkg::PAT_BITS-1:0] pat_str,
    input  wire logic [wesm_pkg::LEN_W-1:0]    pat_len,
    input  wire logic [wesm_pkg::POS_W-1:0]    pos,
    input  wire logic                          enabled,
    input  wire logic [7:0]                    byte_value,
    output logic      [1:0]                    res,
    output logic      [wesm_pkg::POS_W-1:0]    pos_next,
    output logic                               enabled_next
);
    import wesm_pkg::*;

    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] new_pos;
    logic [7:0]       sym;
    logic [7:0]       sym_after;
    logic             ok;
    logic             in_run;
    logic             run_sym;

    // Symbols at the current position and the one after it.
    always_comb
    begin
        start     = ({1'b0, pos} >= pat_len) ? '0 : {1'b0, pos};
        sym       = sym_at(pat_str, pat_len, start);
        sym_after = sym_at(pat_str, pat_len, start + LEN_W'(1));
    end

    // Symbol compare and position update.
    always_comb
    begin
        ok           = 1'b1;
        in_run       = 1'b0;
        run_sym      = 1'b0;
        new_pos      = start + LEN_W'(1);
        res          = ST_IDLE;
        pos_next     = pos;
        enabled_next = enabled;

        if (sym == SYM_ANY)
        begin
            new_pos = start + LEN_W'(1);
        end
        else if (sym == SYM_DIGITS || sym == SYM_PRINTS)
        begin
            run_sym = 1'b1;
            if (sym == SYM_DIGITS)
                in_run = (byte_value >= 8'h30) && (byte_value <= 8'h39);
            else
                in_run = (byte_value >= 8'h20) && (byte_value <= 8'h7E);
            if (!in_run)
            begin
                // The run ends only on the byte that follows it in the pattern.
                if (sym_after == byte_value)
                    new_pos = start + LEN_W'(2);
                else
                    ok = 1'b0;
            end
        end
        else if (sym == SYM_NOT_LF)
        begin
            ok = (byte_value != CHR_LF);
        end
        else if (sym == SYM_NOT_LF_CR)
        begin
            ok = (byte_value != CHR_LF) && (byte_value != CHR_CR);
        end
        else
        begin
            ok = (sym == byte_value);
        end

        if (enabled && pat_len != '0)
        begin
            if (run_sym && in_run)
            begin
                res      = ST_BUSY;
                pos_next = start[POS_W-1:0];
            end
            else if (!ok)
            begin
                res          = ST_IDLE;
                pos_next     = '0;
                enabled_next = 1'b0;
            end
            else if (new_pos >= pat_len)
            begin
                res      = ST_DONE;
                pos_next = '0;
            end
            else
            begin
                res      = ST_BUSY;
                pos_next = new_pos[POS_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wesm_arbiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Group arbiter
// Walks the ordered member list of the selected group, picks the first
// completing pattern and tells which patterns take their lane results and
// which are touched by a rearm action.
// ----------------------------------------------------------------------------
module wesm_arbiter (
    input  wire logic                                   shell_mode,
    input  wire wesm_pkg::in_word_t                     word,
    input  wire logic [wesm_pkg::NUM_PATTERNS-1:0][1:0] lane_res,
    output wesm_pkg::wesm_sel_t                         sel
);
    import wesm_pkg::*;

    logic       grp_ok;
    logic [2:0] gidx;
    logic [4:0] id;
    logic [4:0] pidx;
    logic [1:0] r;
    logic       found;
    logic       busy;
    logic [4:0] winner;

    // Priority walk over the list slots.
    always_comb
    begin
        grp_ok = ({29'd0, word.group} < NUM_GROUPS) && (word.action != ACT_NOP);
        gidx   = grp_ok ? word.group : 3'd0;
        found  = 1'b0;
        busy   = 1'b0;
        winner = '0;
        id     = '0;
        pidx   = '0;
        r      = ST_IDLE;
        sel    = '0;

        for (int s = 0; s < GROUP_SLOTS; s++)
        begin
            id   = grp_ok ? GROUP_ROM[shell_mode][gidx][s] : 5'd0;
            pidx = id - 5'd1;
            if (id != 5'd0)
            begin
                sel.touch_mask[pidx] = 1'b1;
                if (!found)
                begin
                    r                    = lane_res[pidx];
                    sel.check_mask[pidx] = 1'b1;
                    if (r == ST_BUSY)
                        busy = 1'b1;
                    if (r == ST_DONE)
                    begin
                        found  = 1'b1;
                        winner = id;
                    end
                end
            end
        end

        // Only a byte check reports a status.
        if (grp_ok && word.action == ACT_CHECK)
        begin
            sel.result.match_status    = found ? ST_DONE : (busy ? ST_BUSY : ST_IDLE);
            sel.result.matched_pattern = winner;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wildcard_escape_sequence_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard escape sequence matcher
// Matches a terminal output byte stream against a fixed set of escape
// sequence patterns with wildcards, per group and shell, reporting the
// first pattern in group order that completes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Word
//  in       input      in_valid / in_stall     wesm_pkg::in_word_t
//  out      output     out_valid / out_stall   wesm_pkg::out_word_t
//  cfg      input      cfg_valid / cfg_ready   shell_mode (1 bit)
//
//  Each word is held in the input register and is then evaluated combinationally
//  by all pattern lanes in parallel plus the group arbiter; its result lands in
//  the output register. One word per cycle while the output does not stall.
//  Reset clears all positions and enable bits and selects the bash lists.
//  An output stall holds the result and the word waiting in the input register.
// ----------------------------------------------------------------------------
module wildcard_escape_sequence_matcher (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire wesm_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output wesm_pkg::out_word_t      out_word,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);
    import wesm_pkg::*;

    logic                                s1_valid_reg;
    in_word_t                            s1_word_reg;
    logic                                out_valid_reg;
    out_word_t                           out_word_reg;
    logic                                shell_mode_reg;
    logic [POS_W-1:0]                    pos_reg [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0]             en_reg;
    logic [NUM_PATTERNS-1:0][1:0]        lane_res;
    logic [POS_W-1:0]                    lane_pos [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0]             lane_en;
    wesm_sel_t                           sel;
    logic                                s1_go;
    logic                                accept;

    // Handshake.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shell_mode_reg <= 1'b0;
        else if (cfg_valid)
            shell_mode_reg <= cfg_data;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_word_reg <= in_word;
    end

    // One lane per pattern.
    for (genvar p = 0; p < NUM_PATTERNS; p++)
    begin : g_lane
        wesm_lane u_lane (
            .pat_str      (PAT_STR[p]),
            .pat_len      (PAT_LEN[p]),
            .pos          (pos_reg[p]),
            .enabled      (en_reg[p]),
            .byte_value   (s1_word_reg.byte_value),
            .res          (lane_res[p]),
            .pos_next     (lane_pos[p]),
            .enabled_next (lane_en[p])
        );
    end

    // Priority pick over the selected group.
    wesm_arbiter u_arbiter (
        .shell_mode (shell_mode_reg),
        .word       (s1_word_reg),
        .lane_res   (lane_res),
        .sel        (sel)
    );

    // Pattern state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= '0;
            for (int p = 0; p < NUM_PATTERNS; p++)
                pos_reg[p] <= '0;
        end
        else if (s1_go)
        begin
            for (int p = 0; p < NUM_PATTERNS; p++)
            begin
                case (s1_word_reg.action)
                    ACT_CHECK:
                        if (sel.check_mask[p])
                        begin
                            pos_reg[p] <= lane_pos[p];
                            en_reg[p]  <= lane_en[p];
                        end
                    ACT_ENABLE:
                        if (sel.touch_mask[p])
                            en_reg[p] <= 1'b1;
                    ACT_CLEAR:
                        if (sel.touch_mask[p])
                            pos_reg[p] <= '0;
                    default:
                        ;
                endcase
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
            out_word_reg <= sel.result;
    end

endmodule
`default_nettype wire

// ===== sim/tb_wildcard_escape_sequence_matcher.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the wildcard escape sequence matcher
// Sends check, enable, clear and no-op words through the input channel with
// random gaps and output stalls. A behavioral model of the pattern lanes and
// group lists predicts every result word, and the monitor compares each field.
// ----------------------------------------------------------------------------
module tb_wildcard_escape_sequence_matcher;
    import wesm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;

    // Escape character that opens the directed escape sequence.
    localparam logic [7:0] ASCII_ESC      = 8'h1B;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    // Pattern text, pattern number minus one as index.
    string pattern_text [18] = '{
        "\033[0;30m\033[0m\033[1;37m\033[0m",
        "\033[0;34m\033[0m\033[0;31m\033[0m",
        "\033[0;34m\033[0m\033[0;31m\033[0m\033[\026D",
        "\033P\022\033\\",
        "\007",
        "\030",
        "\033[0m\033[27m\033[24m\015\033[\026C",
        " \015\023",
        "\015\024",
        "\015\n",
        "\010",
        "\033[\026C",
        "\033[\026D",
        "\033[\026A",
        "\033[\026K",
        "\033[\026P",
        "\033[\026@",
        "\007"
    };

    // Ordered member lists per shell and group; zero is an empty slot.
    int unsigned group_list [2][5][16] = '{
        '{
            '{5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, 4, 8, 12, 11, 15, 16, 17, 13, 18, 14, 9, 10, 0, 0, 0},
            '{1, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
        },
        '{
            '{5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{1, 2, 8, 12, 11, 15, 16, 17, 13, 18, 14, 9, 10, 4, 0, 0},
            '{1, 3, 4, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
        }
    };

    // Predicted matcher state.
    int unsigned lane_pos [18];
    bit          lane_on [18];
    bit          shell_sel = 1'b0;

    in_word_t  pending_words [$];
    out_word_t expected_matches [$];
    int        item_total = 0;
    int        fail_count = 0;
    int        cycle_count = 0;
    int        send_gap = 0;
    int        stall_left = 0;
    bit        calm = 1'b0;

    wildcard_escape_sequence_matcher DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Character of a pattern at an index; zero at or past the end.
    function automatic logic [7:0] pattern_char(int p, int i);
        if (i >= pattern_text[p].len())
            return 8'h00;
        return pattern_text[p][i];
    endfunction

    // Advance one pattern lane by a byte and return its lane status.
    function automatic logic [1:0] advance_lane(int p, logic [7:0] c);
        int         len;
        int         cur;
        logic [7:0] sym;
        bit         ok;
        bit         in_run;
        len = pattern_text[p].len();
        cur = lane_pos[p];
        ok = 1'b1;
        if (!lane_on[p] || len == 0)
            return ST_IDLE;
        if (cur >= len)
            cur = 0;
        sym = pattern_char(p, cur);
        if (sym == SYM_ANY)
        begin
            cur++;
        end
        else if (sym == SYM_DIGITS || sym == SYM_PRINTS)
        begin
            in_run = (sym == SYM_DIGITS) ? (c >= "0" && c <= "9")
                                         : (c >= 8'h20 && c <= 8'h7E);
            if (in_run)
            begin
                lane_pos[p] = cur;
                return ST_BUSY;
            end
            if (pattern_char(p, cur + 1) == c)
                cur += 2;
            else
                ok = 1'b0;
        end
        else if (sym == SYM_NOT_LF)
        begin
            if (c == CHR_LF) ok = 1'b0; else cur++;
        end
        else if (sym == SYM_NOT_LF_CR)
        begin
            if (c == CHR_LF || c == CHR_CR) ok = 1'b0; else cur++;
        end
        else
        begin
            if (sym == c) cur++; else ok = 1'b0;
        end
        if (!ok)
        begin
            lane_pos[p] = 0;
            lane_on[p] = 1'b0;
            return ST_IDLE;
        end
        if (cur >= len)
        begin
            lane_pos[p] = 0;
            return ST_DONE;
        end
        lane_pos[p] = cur;
        return ST_BUSY;
    endfunction

    // Apply one word to the predicted state and return its result word.
    function automatic out_word_t predict_match(in_word_t w);
        out_word_t   res;
        logic [1:0]  status;
        logic [1:0]  lane;
        int unsigned id;
        int unsigned hit;
        int          s;
        status = ST_IDLE;
        hit = 0;
        if (w.group < 5 && w.action != ACT_NOP)
        begin
            for (s = 0; s < 16 && hit == 0; s++)
            begin
                id = group_list[shell_sel][w.group][s];
                if (id != 0)
                begin
                    if (w.action == ACT_ENABLE)
                        lane_on[id - 1] = 1'b1;
                    else if (w.action == ACT_CLEAR)
                        lane_pos[id - 1] = 0;
                    else
                    begin
                        lane = advance_lane(id - 1, w.byte_value);
                        status |= lane;
                        if (lane == ST_DONE)
                            hit = id;
                    end
                end
            end
        end
        res.match_status = (hit != 0) ? ST_DONE : (status[0] ? ST_BUSY : ST_IDLE);
        res.matched_pattern = hit[4:0];
        return res;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_item(logic [1:0] act, logic [7:0] b, logic [2:0] g);
        in_word_t w;
        w.action = act;
        w.byte_value = b;
        w.group = g;
        pending_words.push_back(w);
        if (act != ACT_NOP && g < 5)
            item_total++;
    endtask

    // Queue the bytes of one pattern with random wildcard content,
    // sometimes with one byte broken.
    task automatic queue_pattern(int p, logic [2:0] g);
        logic [7:0] seq [$];
        logic [7:0] ch;
        logic [7:0] b;
        int         i;
        int         k;
        int         n;
        for (i = 0; i < pattern_text[p].len(); i++)
        begin
            ch = pattern_char(p, i);
            case (ch)
                SYM_DIGITS:
                begin
                    n = $urandom_range(0, 3);
                    for (k = 0; k < n; k++)
                        seq.push_back(8'(8'h30 + $urandom_range(0, 9)));
                end
                SYM_PRINTS:
                begin
                    n = $urandom_range(0, 4);
                    for (k = 0; k < n; k++)
                        seq.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                SYM_NOT_LF, SYM_NOT_LF_CR:
                begin
                    b = CHR_LF;
                    while (b == CHR_LF || (ch == SYM_NOT_LF_CR && b == CHR_CR))
                        b = 8'($urandom_range(0, 255));
                    seq.push_back(b);
                end
                SYM_ANY:
                    seq.push_back(8'($urandom_range(0, 255)));
                default:
                    seq.push_back(ch);
            endcase
        end
        if ($urandom_range(0, 9) == 0)
            seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom_range(0, 255));
        foreach (seq[k])
            add_item(ACT_CHECK, seq[k], g);
    endtask

    // Random words: mostly rearm plus a member pattern, the rest noise.
    task automatic queue_random(int count);
        int unsigned members [$];
        int          goal;
        int          r;
        int          s;
        logic [2:0]  g;
        goal = item_total + count;
        while (item_total < goal)
        begin
            r = $urandom_range(0, 99);
            g = 3'($urandom_range(0, 4));
            members.delete();
            for (s = 0; s < 16; s++)
                if (group_list[shell_sel][g][s] != 0)
                    members.push_back(group_list[shell_sel][g][s]);
            if (r < 12 || members.size() == 0)
            begin
                add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         3'($urandom_range(0, 7)));
            end
            else
            begin
                if (r < 70)
                    add_item(ACT_ENABLE, 8'($urandom_range(0, 255)), g);
                else if (r < 82)
                    add_item(ACT_CLEAR, 8'($urandom_range(0, 255)), g);
                if ($urandom_range(0, 3) == 0)
                    add_item(ACT_CHECK, 8'($urandom_range(0, 255)), g);
                queue_pattern(members[$urandom_range(0, members.size() - 1)] - 1, g);
            end
        end
    endtask

    // Wait until every queued word is sent and answered, then let the
    // pipeline settle.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_shell(logic mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shell_sel = mode;
    endtask

    // Input driver: predicts each accepted word and presents the next one.
    always @(posedge clk)
    begin : drive_words
        logic     nxt_valid;
        in_word_t nxt_word;
        nxt_valid = in_valid;
        nxt_word = in_word;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_matches.push_back(predict_match(in_word));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_words.size() != 0)
                begin
                    nxt_word = pending_words.pop_front();
                    nxt_valid = 1'b1;
                    send_gap = pick_gap();
                end
            end
        end
        in_valid <= nxt_valid;
        in_word <= nxt_word;
    end

    // Output monitor: checks each accepted result word and drives stalls.
    always @(posedge clk)
    begin : watch_results
        out_word_t want;
        int        n;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    $display("%0t unexpected result: status %0d pattern %0d",
                             $time, out_word.match_status, out_word.matched_pattern);
                    fail_count++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (out_word.match_status !== want.match_status)
                    begin
                        $display("%0t match_status mismatch: expected %0d, actual %0d",
                                 $time, want.match_status, out_word.match_status);
                        fail_count++;
                    end
                    if (out_word.matched_pattern !== want.matched_pattern)
                    begin
                        $display("%0t matched_pattern mismatch: expected %0d, actual %0d",
                                 $time, want.matched_pattern, out_word.matched_pattern);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                n = pick_gap();
                out_stall <= (n != 0);
                stall_left = (n != 0) ? n - 1 : 0;
            end
        end
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus phases.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words on the bash lists.
        write_shell(1'b0);
        calm = 1'b1;
        add_item(ACT_CHECK, 8'h07, 3'd0);
        add_item(ACT_ENABLE, 8'h00, 3'd0);
        add_item(ACT_CHECK, 8'h07, 3'd0);
        add_item(ACT_CHECK, 8'h00, 3'd3);
        add_item(ACT_NOP, 8'hFF, 3'd1);
        add_item(ACT_CHECK, 8'hFF, 3'd7);
        add_item(ACT_ENABLE, 8'h00, 3'd1);
        add_item(ACT_CHECK, ASCII_ESC, 3'd1);
        add_item(ACT_CHECK, "[", 3'd1);
        add_item(ACT_CHECK, "4", 3'd1);
        add_item(ACT_CHECK, "2", 3'd1);
        add_item(ACT_CHECK, "C", 3'd1);
        add_item(ACT_CLEAR, 8'h00, 3'd1);
        add_item(ACT_ENABLE, 8'h00, 3'd4);
        add_item(ACT_CHECK, 8'hFF, 3'd4);
        add_item(ACT_CHECK, 8'h00, 3'd4);
        add_item(ACT_ENABLE, 8'h00, 3'd1);
        add_item(ACT_CHECK, " ", 3'd1);
        add_item(ACT_CHECK, CHR_CR, 3'd1);
        add_item(ACT_CHECK, CHR_LF, 3'd1);
        add_item(ACT_CHECK, 8'h80, 3'd2);
        drain();

        // Random phases over both shell settings, with and without idling.
        write_shell(1'b1);
        calm = 1'b0;
        queue_random(100);
        drain();

        write_shell(1'b0);
        calm = 1'b1;
        queue_random(60);
        drain();

        write_shell(1'b1);
        calm = 1'b0;
        queue_random(120);
        drain();

        write_shell(1'b0);
        queue_random(120);
        drain();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
